// File: rtl/core/mvs_pkg.sv
// ----------------------------------------------------------------------------
// mvs_pkg
// Shared constants and types for the matrix mean / variance / deviation block.
// ----------------------------------------------------------------------------
package mvs_pkg;

	localparam int CFG_W     = 7;
	localparam int REG_IDX_W = 2;
	localparam int AXIS_W    = 2;
	localparam int IN_W      = 16;
	localparam int AVG_W     = 16;
	localparam int SPREAD_W  = 31;
	localparam int DEV_W     = 16;
	localparam int GIDX_W    = 6;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [AXIS_W-1:0]    axis_t;

	localparam reg_idx_t REG_ROWS = 2'd0;
	localparam reg_idx_t REG_COLS = 2'd1;
	localparam reg_idx_t REG_AXIS = 2'd2;

	localparam axis_t AXIS_ROW = 2'd0;
	localparam axis_t AXIS_COL = 2'd1;
	localparam axis_t AXIS_ALL = 2'd2;

endpackage

// File: rtl/core/mvs_ram.sv
// ----------------------------------------------------------------------------
// mvs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/mvs_engine.sv
// ----------------------------------------------------------------------------
// mvs_engine
// Bit-serial statistics unit: shift-add products, restoring divides and a
// digit-by-digit square root for one group of samples.
// ----------------------------------------------------------------------------
module mvs_engine #(
	parameter int SAMPLE_BITS = 16,
	parameter int CNT_W = 13,
	localparam int SUM_W = SAMPLE_BITS + CNT_W,
	localparam int SQ_W = 2 * SAMPLE_BITS - 1 + CNT_W,
	localparam int VAR_W = 2 * SAMPLE_BITS - 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CNT_W-1:0]        n_in,
	input  logic signed [SUM_W-1:0] sum_in,
	input  logic [SQ_W-1:0]         sq_in,
	output logic                    done,
	output logic [SAMPLE_BITS-1:0]  avg,
	output logic [VAR_W-1:0]        var_o,
	output logic [SAMPLE_BITS-1:0]  dev
);

	localparam int PROD_W = 2 * SUM_W;
	localparam int NN_W   = 2 * CNT_W;
	localparam int SR_W   = SAMPLE_BITS + 4;
	localparam int CTR_W  = $clog2(PROD_W + 1);

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_MUL  = 3'd1;
	localparam logic [2:0] P_SUB  = 3'd2;
	localparam logic [2:0] P_DIV  = 3'd3;
	localparam logic [2:0] P_SQRT = 3'd4;
	localparam logic [2:0] P_DONE = 3'd5;

	logic [2:0]       phase_q;
	logic [CTR_W-1:0] ctr_q;

	logic                   neg_q;
	logic [CNT_W-1:0]       n_q;
	logic [SUM_W-1:0]       dm_q;
	logic [CNT_W:0]         mrem_q;
	logic [SUM_W-1:0]       mq_q;
	logic [CNT_W-1:0]       mul_n_q;
	logic [PROD_W-1:0]      sq_sh_q;
	logic [PROD_W-1:0]      acc_a_q;
	logic [SUM_W-1:0]       mb_q;
	logic [PROD_W-1:0]      m_sh_q;
	logic [PROD_W-1:0]      acc_b_q;
	logic [NN_W-1:0]        nn_sh_q;
	logic [NN_W-1:0]        nn_q;
	logic [PROD_W-1:0]      dd_q;
	logic [NN_W:0]          vrem_q;
	logic [VAR_W-1:0]       vq_q;
	logic [2*SAMPLE_BITS-1:0] sv_q;
	logic [SR_W-1:0]        srem_q;
	logic [SAMPLE_BITS-1:0] root_q;
	logic [SAMPLE_BITS-1:0] avg_q;

	logic [SUM_W-1:0] mag;
	logic [CNT_W:0]   m_trial;
	logic             m_ge;
	logic [NN_W:0]    v_trial;
	logic             v_ge;
	logic [SR_W-1:0]  s_t;
	logic [SR_W-1:0]  s_trial;
	logic             s_ge;
	logic [SUM_W-1:0] mean_full;
	logic             last_step;

	assign mag = sum_in[SUM_W-1] ? SUM_W'(0) - SUM_W'(unsigned'(sum_in))
		: SUM_W'(unsigned'(sum_in));

	assign m_trial = {mrem_q[CNT_W-1:0], dm_q[SUM_W-1]};
	assign m_ge    = m_trial >= {1'b0, n_q};
	assign v_trial = {vrem_q[NN_W-1:0], dd_q[PROD_W-1]};
	assign v_ge    = v_trial >= {1'b0, nn_q};
	assign s_t     = {srem_q[SR_W-3:0], sv_q[2*SAMPLE_BITS-1 -: 2]};
	assign s_trial = SR_W'({root_q, 2'b01});
	assign s_ge    = s_t >= s_trial;

	// floor for negative sums: round the magnitude quotient up
	assign mean_full = neg_q ? SUM_W'(0) - (mq_q + SUM_W'(mrem_q != '0)) : mq_q;

	always_comb begin
		case (phase_q)
			P_MUL:   last_step = ctr_q == CTR_W'(SUM_W - 1);
			P_DIV:   last_step = ctr_q == CTR_W'(PROD_W - 1);
			P_SQRT:  last_step = ctr_q == CTR_W'(SAMPLE_BITS - 1);
			default: last_step = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			ctr_q   <= '0;
		end else if (start) begin
			phase_q <= P_MUL;
			ctr_q   <= '0;
		end else begin
			case (phase_q)
				P_MUL, P_DIV, P_SQRT: begin
					ctr_q <= last_step ? '0 : ctr_q + 1'b1;
					if (last_step) begin
						phase_q <= phase_q == P_MUL ? P_SUB
							: (phase_q == P_DIV ? P_SQRT : P_DONE);
					end
				end
				P_SUB:   phase_q <= P_DIV;
				default: phase_q <= phase_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= sum_in[SUM_W-1];
			n_q     <= n_in;
			dm_q    <= mag;
			mrem_q  <= '0;
			mq_q    <= '0;
			mul_n_q <= n_in;
			sq_sh_q <= PROD_W'(sq_in);
			acc_a_q <= '0;
			mb_q    <= mag;
			m_sh_q  <= PROD_W'(mag);
			acc_b_q <= '0;
			nn_sh_q <= NN_W'(n_in);
			nn_q    <= '0;
		end else begin
			case (phase_q)
				P_MUL: begin
					if (mul_n_q[0]) begin
						acc_a_q <= acc_a_q + sq_sh_q;
						nn_q    <= nn_q + nn_sh_q;
					end
					if (mb_q[0]) begin
						acc_b_q <= acc_b_q + m_sh_q;
					end
					mul_n_q <= mul_n_q >> 1;
					sq_sh_q <= sq_sh_q << 1;
					nn_sh_q <= nn_sh_q << 1;
					mb_q    <= mb_q >> 1;
					m_sh_q  <= m_sh_q << 1;
					mrem_q  <= m_ge ? m_trial - {1'b0, n_q} : m_trial;
					mq_q    <= {mq_q[SUM_W-2:0], m_ge};
					dm_q    <= dm_q << 1;
				end
				P_SUB: begin
					dd_q   <= acc_a_q > acc_b_q ? acc_a_q - acc_b_q : '0;
					avg_q  <= SAMPLE_BITS'(mean_full);
					vrem_q <= '0;
					vq_q   <= '0;
				end
				P_DIV: begin
					vrem_q <= v_ge ? v_trial - {1'b0, nn_q} : v_trial;
					vq_q   <= {vq_q[VAR_W-2:0], v_ge};
					dd_q   <= dd_q << 1;
					if (last_step) begin
						sv_q   <= {1'b0, vq_q[VAR_W-2:0], v_ge};
						srem_q <= '0;
						root_q <= '0;
					end
				end
				P_SQRT: begin
					srem_q <= s_ge ? s_t - s_trial : s_t;
					root_q <= {root_q[SAMPLE_BITS-2:0], s_ge};
					sv_q   <= sv_q << 2;
				end
				default: begin
				end
			endcase
		end
	end

	assign done  = phase_q == P_DONE;
	assign avg   = avg_q;
	assign var_o = vq_q;
	assign dev   = root_q;

endmodule

// File: rtl/core/matrix_axis_mean_variance_std.sv
// ----------------------------------------------------------------------------
// matrix_axis_mean_variance_std
// Per-row, per-column or whole-matrix mean, population variance and
// standard deviation over a streamed matrix of signed samples.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | flow
//  ---------+-------------------------------------------+----------------
//  input    | in_valid, in_stall, sample                | valid / stall
//  output   | out_valid, out_stall, avg, spread,        | valid / stall
//           | deviation, group_index, last              |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | valid / ready
//
//  a beat that closes no group is accepted, then accumulated, before the next is taken
//  a group result runs the bit-serial unit through its multiply and mean divide,
//  subtract, variance divide and square-root steps; a column burst runs the
//  unit once per column, each run after a read of that column from the store
//  reset clears positions and running sums; the column store needs none
//  a stalled output beat blocks the input only once the next result is ready
//  config is taken only while idle between beats
module matrix_axis_mean_variance_std #(
	parameter int MAX_DIM = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mvs_pkg::IN_W-1:0]      sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mvs_pkg::AVG_W-1:0]     avg,
	output logic [mvs_pkg::SPREAD_W-1:0]  spread,
	output logic [mvs_pkg::DEV_W-1:0]     deviation,
	output logic [mvs_pkg::GIDX_W-1:0]    group_index,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  mvs_pkg::reg_idx_t             cfg_index,
	input  logic [mvs_pkg::CFG_W-1:0]     cfg_data
);

	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W     = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int SUM_W     = SAMPLE_BITS + CNT_W;
	localparam int SQ1_W     = 2 * SAMPLE_BITS - 1;
	localparam int SQ_W      = SQ1_W + CNT_W;
	localparam int COL_SUM_W = SAMPLE_BITS + DIM_W;
	localparam int COL_SQ_W  = SQ1_W + DIM_W;
	localparam int VAR_W     = 2 * SAMPLE_BITS - 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ACC   = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_COLRD = 3'd4;
	localparam logic [2:0] S_COLLD = 3'd5;

	logic [2:0] state_q;

	logic [mvs_pkg::CFG_W-1:0] rows_q;
	logic [mvs_pkg::CFG_W-1:0] cols_q;
	mvs_pkg::axis_t            axis_q;

	logic [IDX_W-1:0]        row_pos_q;
	logic [IDX_W-1:0]        col_pos_q;
	logic signed [SUM_W-1:0] run_sum_q;
	logic [SQ_W-1:0]         run_sq_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        col_idx_q;
	logic                    burst_q;

	logic signed [SAMPLE_BITS-1:0] s_q;
	logic [SQ1_W-1:0]              sq_q;

	logic [CNT_W-1:0]        job_n_q;
	logic signed [SUM_W-1:0] job_sum_q;
	logic [SQ_W-1:0]         job_sq_q;
	logic [IDX_W-1:0]        job_idx_q;
	logic                    job_last_q;

	logic [DIM_W-1:0] nr;
	logic [DIM_W-1:0] nc;
	logic             end_row;
	logic             end_mat;
	logic             axis_row;
	logic             axis_col;

	logic [SAMPLE_BITS-1:0]          raw;
	logic signed [SAMPLE_BITS-1:0]   s_in;
	logic signed [2*SAMPLE_BITS-1:0] sq_full;

	logic signed [SUM_W-1:0] sum_next;
	logic [SQ_W-1:0]         sq_next;

	logic [IDX_W-1:0]                raddr;
	logic [COL_SUM_W+COL_SQ_W-1:0]   rdata;
	logic [COL_SUM_W+COL_SQ_W-1:0]   wdata;
	logic signed [COL_SUM_W-1:0]     rd_sum;
	logic [COL_SQ_W-1:0]             rd_sq;
	logic signed [COL_SUM_W-1:0]     new_csum;
	logic [COL_SQ_W-1:0]             new_csq;
	logic                            col_we;

	logic                   eng_start;
	logic                   eng_done;
	logic [SAMPLE_BITS-1:0] eng_avg;
	logic [VAR_W-1:0]       eng_var;
	logic [SAMPLE_BITS-1:0] eng_dev;
	logic                   out_free;
	logic                   out_load;
	logic                   in_take;
	logic                   cfg_take;
	logic                   last_col;

	always_comb begin
		if (rows_q == '0) begin
			nr = DIM_W'(1);
		end else if (rows_q > MAX_DIM) begin
			nr = DIM_W'(MAX_DIM);
		end else begin
			nr = DIM_W'(rows_q);
		end
		if (cols_q == '0) begin
			nc = DIM_W'(1);
		end else if (cols_q > MAX_DIM) begin
			nc = DIM_W'(MAX_DIM);
		end else begin
			nc = DIM_W'(cols_q);
		end
	end

	assign axis_row = axis_q == mvs_pkg::AXIS_ROW;
	assign axis_col = axis_q == mvs_pkg::AXIS_COL;
	assign end_row  = DIM_W'(col_pos_q) == nc - DIM_W'(1);
	assign end_mat  = end_row && (DIM_W'(row_pos_q) == nr - DIM_W'(1));
	assign last_col = DIM_W'(col_idx_q) == nc - DIM_W'(1);

	assign raw     = SAMPLE_BITS'(sample);
	assign s_in    = signed'(raw);
	assign sq_full = s_in * s_in;

	assign sum_next = run_sum_q + SUM_W'(s_q);
	assign sq_next  = run_sq_q + SQ_W'(sq_q);

	assign rd_sum   = signed'(rdata[COL_SUM_W+COL_SQ_W-1:COL_SQ_W]);
	assign rd_sq    = rdata[COL_SQ_W-1:0];
	assign new_csum = (row_pos_q == '0) ? COL_SUM_W'(s_q) : rd_sum + COL_SUM_W'(s_q);
	assign new_csq  = (row_pos_q == '0) ? COL_SQ_W'(sq_q) : rd_sq + COL_SQ_W'(sq_q);
	assign wdata    = {new_csum, new_csq};
	assign col_we   = state_q == S_ACC && axis_col;
	assign raddr    = (state_q == S_COLRD) ? col_idx_q : col_pos_q;

	assign in_stall  = state_q != S_IDLE;
	assign in_take   = in_valid && state_q == S_IDLE;
	assign cfg_ready = state_q == S_IDLE;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid || !out_stall;
	assign out_load  = state_q == S_WAIT && eng_done && out_free;
	assign eng_start = state_q == S_START;

	mvs_ram #(
		.WIDTH(COL_SUM_W + COL_SQ_W),
		.DEPTH(MAX_DIM)
	) u_col_ram (
		.clk  (clk),
		.we   (col_we),
		.waddr(col_pos_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	mvs_engine #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.CNT_W(CNT_W)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (eng_start),
		.n_in  (job_n_q),
		.sum_in(job_sum_q),
		.sq_in (job_sq_q),
		.done  (eng_done),
		.avg   (eng_avg),
		.var_o (eng_var),
		.dev   (eng_dev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rows_q    <= mvs_pkg::CFG_W'(1);
			cols_q    <= mvs_pkg::CFG_W'(1);
			axis_q    <= mvs_pkg::AXIS_ALL;
			row_pos_q <= '0;
			col_pos_q <= '0;
			run_sum_q <= '0;
			run_sq_q  <= '0;
			count_q   <= '0;
			col_idx_q <= '0;
			burst_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (cfg_take && cfg_index inside {mvs_pkg::REG_ROWS, mvs_pkg::REG_COLS,
					mvs_pkg::REG_AXIS}) begin
				case (cfg_index)
					mvs_pkg::REG_ROWS: rows_q <= cfg_data;
					mvs_pkg::REG_COLS: cols_q <= cfg_data;
					default:           axis_q <= cfg_data[mvs_pkg::AXIS_W-1:0];
				endcase
				row_pos_q <= '0;
				col_pos_q <= '0;
				run_sum_q <= '0;
				run_sq_q  <= '0;
				count_q   <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if ((axis_row && end_row) || end_mat) begin
						run_sum_q <= '0;
						run_sq_q  <= '0;
					end else if (!axis_col) begin
						run_sum_q <= sum_next;
						run_sq_q  <= sq_next;
					end
					if (end_row) begin
						col_pos_q <= '0;
						if (end_mat) begin
							row_pos_q <= '0;
							count_q   <= '0;
						end else begin
							row_pos_q <= row_pos_q + 1'b1;
							count_q   <= count_q + 1'b1;
						end
					end else begin
						col_pos_q <= col_pos_q + 1'b1;
						count_q   <= count_q + 1'b1;
					end
					if (axis_col) begin
						if (end_mat) begin
							col_idx_q <= '0;
							burst_q   <= 1'b1;
							state_q   <= S_COLRD;
						end else begin
							state_q <= S_IDLE;
						end
					end else if ((axis_row && end_row) || end_mat) begin
						state_q <= S_START;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_COLRD: state_q <= S_COLLD;
				S_COLLD: state_q <= S_START;
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (out_load) begin
						if (burst_q && !last_col) begin
							col_idx_q <= col_idx_q + 1'b1;
							state_q   <= S_COLRD;
						end else begin
							burst_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			s_q  <= s_in;
			sq_q <= SQ1_W'(unsigned'(sq_full));
		end
		if (state_q == S_ACC) begin
			job_sum_q  <= sum_next;
			job_sq_q   <= sq_next;
			job_idx_q  <= axis_row ? row_pos_q : '0;
			job_last_q <= end_mat;
			job_n_q    <= axis_row ? CNT_W'(nc) : count_q + 1'b1;
		end
		if (state_q == S_COLLD) begin
			job_sum_q  <= SUM_W'(rd_sum);
			job_sq_q   <= SQ_W'(rd_sq);
			job_idx_q  <= col_idx_q;
			job_last_q <= last_col;
			job_n_q    <= CNT_W'(nr);
		end
		if (out_load) begin
			avg         <= mvs_pkg::AVG_W'(signed'(eng_avg));
			spread      <= mvs_pkg::SPREAD_W'(eng_var);
			deviation   <= mvs_pkg::DEV_W'(eng_dev);
			group_index <= mvs_pkg::GIDX_W'(job_idx_q);
			last        <= job_last_q;
		end
	end

endmodule

// File: rtl/core/mvs_checker.sv
// ----------------------------------------------------------------------------
// mvs_checker
// Port-level checks for the matrix statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module mvs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [mvs_pkg::AVG_W-1:0]     avg,
	input logic [mvs_pkg::SPREAD_W-1:0]  spread,
	input logic [mvs_pkg::DEV_W-1:0]     deviation,
	input logic [mvs_pkg::GIDX_W-1:0]    group_index,
	input logic                          last
);

	// a stalled result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(avg) && $stable(spread)
			&& $stable(deviation) && $stable(group_index) && $stable(last))
		else $error("stalled result beat changed");

	// one sample at a time: an accepted beat blocks the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted beat");

	// deviation brackets the square root of spread
	a_sqrt_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (33'(deviation) * 33'(deviation) <= 33'(spread))
			&& ((33'(deviation) + 33'd1) * (33'(deviation) + 33'd1) > 33'(spread)))
		else $error("deviation is not floor sqrt of spread");

	// population variance of 16-bit samples stays within a quarter of the range squared
	a_spread_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> spread <= 31'd1073741824)
		else $error("spread above bound");

endmodule

bind matrix_axis_mean_variance_std mvs_checker u_mvs_checker (.*);
